[sv/ut_pkg.sv]
`timescale 1ns / 1ps
package ut_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PADDR_W     = 3;

    localparam logic [1:0] SRC_LATIN1 = 2'd0;
    localparam logic [1:0] SRC_UTF16  = 2'd1;
    localparam logic [1:0] SRC_UTF32  = 2'd2;

    localparam logic [1:0] ENC_UTF8  = 2'd0;
    localparam logic [1:0] ENC_UTF16 = 2'd1;
    localparam logic [1:0] ENC_UTF32 = 2'd2;
    localparam logic [1:0] ENC_NONE  = 2'd3;

    localparam logic [1:0] SRC_MODE_RESET = SRC_UTF32;
    localparam logic [1:0] TGT_ENC_RESET  = ENC_UTF8;

    localparam logic REG_SOURCE_MODE = 1'b0;
    localparam logic REG_TARGET_ENC  = 1'b1;

    localparam logic [31:0] LIM_1BYTE  = 32'h0000_0080;
    localparam logic [31:0] LIM_2BYTE  = 32'h0000_0800;
    localparam logic [31:0] LIM_3BYTE  = 32'h0001_0000;
    localparam logic [31:0] SUPP_BASE  = 32'h0001_0000;
    localparam logic [31:0] HI_SURR    = 32'h0000_D800;
    localparam logic [31:0] LO_SURR    = 32'h0000_DC00;
    localparam logic [15:0] HI_SURR_16 = 16'hD800;

    typedef enum logic [1:0] {
        K_RAW,
        K_UTF8,
        K_UTF16
    } t_kind;

    typedef struct packed {
        logic [1:0] source_mode;
        logic [1:0] target_encoding;
    } t_cfg;

    typedef struct packed {
        logic [31:0] cp;
        t_kind       kind;
        logic        last_in;
    } t_entry;

endpackage

[sv/ut_front.sv]
`timescale 1ns / 1ps
module ut_front
    import ut_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_cfg_wr,
    input  logic        i_valid,
    input  logic [31:0] i_code_unit,
    input  logic        i_string_end,
    input  logic        i_full,
    output logic        o_ready,
    output logic        o_push,
    output t_entry      o_entry,
    output logic        o_pending
);

    logic        r_pending;
    logic        n_pending;
    logic [15:0] r_held;
    logic [15:0] n_held;
    logic        w_accept;
    logic        w_result;
    logic [15:0] w_u;
    logic        w_is_hi;
    logic [31:0] w_join;

    assign o_ready   = !i_full;
    assign w_accept  = i_valid && !i_full;
    assign o_pending = r_pending;
    assign w_u       = i_code_unit[15:0];
    assign w_is_hi   = (w_u[15:10] == HI_SURR_16[15:10]);
    assign w_join    = (({16'd0, r_held} - HI_SURR) << 10) + ({16'd0, w_u} - LO_SURR) + SUPP_BASE;

    always_comb begin
        w_result         = 1'b0;
        n_pending        = r_pending;
        n_held           = r_held;
        o_entry.cp       = i_code_unit;
        o_entry.last_in  = i_string_end;
        unique case (i_cfg.target_encoding)
            ENC_UTF8:  o_entry.kind = K_UTF8;
            ENC_UTF16: o_entry.kind = (i_cfg.source_mode == SRC_UTF16) ? K_RAW : K_UTF16;
            default:   o_entry.kind = K_RAW;
        endcase
        if (i_cfg.target_encoding != ENC_NONE) begin
            unique case (i_cfg.source_mode)
                SRC_LATIN1: begin
                    o_entry.cp = {24'd0, i_code_unit[7:0]};
                    w_result   = 1'b1;
                end
                SRC_UTF16: begin
                    o_entry.cp = {16'd0, w_u};
                    priority if (i_cfg.target_encoding == ENC_UTF16) begin
                        w_result = 1'b1;
                    end else if (r_pending) begin
                        o_entry.cp = w_join;
                        n_pending  = 1'b0;
                        n_held     = '0;
                        w_result   = 1'b1;
                    end else if (w_is_hi && !i_string_end) begin
                        n_pending = 1'b1;
                        n_held    = w_u;
                    end else begin
                        w_result = 1'b1;
                    end
                end
                default: begin
                    w_result = 1'b1;
                end
            endcase
        end
    end

    assign o_push = w_accept && w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr) begin
            r_pending <= 1'b0;
            r_held    <= '0;
        end else if (w_accept) begin
            r_pending <= n_pending;
            r_held    <= n_held;
        end
    end

endmodule

[sv/ut_queue.sv]
`timescale 1ns / 1ps
module ut_queue
    import ut_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_empty,
    output logic   o_full
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

endmodule

[sv/ut_back.sv]
`timescale 1ns / 1ps
module ut_back
    import ut_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_unit,
    output logic [2:0]  o_run_length,
    output logic        o_last_of_run,
    output logic        o_end_out
);

    logic [1:0]  r_idx;
    logic        r_valid;
    logic [31:0] r_unit;
    logic [2:0]  r_len;
    logic        r_last;
    logic        r_end;
    logic [2:0]  w_len;
    logic [31:0] w_units [4];
    logic [31:0] w_d;
    logic        w_load;
    logic        w_last;
    logic [31:0] c;

    assign c   = i_head.cp;
    assign w_d = c - SUPP_BASE;

    always_comb begin
        w_len    = 3'd1;
        w_units[0] = c;
        w_units[1] = '0;
        w_units[2] = '0;
        w_units[3] = '0;
        unique case (i_head.kind)
            K_UTF8: begin
                priority if (c < LIM_1BYTE) begin
                    w_len = 3'd1;
                end else if (c < LIM_2BYTE) begin
                    w_len      = 3'd2;
                    w_units[0] = {24'd0, 3'b110, c[10:6]};
                    w_units[1] = {24'd0, 2'b10, c[5:0]};
                end else if (c < LIM_3BYTE) begin
                    w_len      = 3'd3;
                    w_units[0] = {24'd0, 4'hE, c[15:12]};
                    w_units[1] = {24'd0, 2'b10, c[11:6]};
                    w_units[2] = {24'd0, 2'b10, c[5:0]};
                end else begin
                    w_len      = 3'd4;
                    w_units[0] = {24'd0, c[25:18] | 8'hF0};
                    w_units[1] = {24'd0, 2'b10, c[17:12]};
                    w_units[2] = {24'd0, 2'b10, c[11:6]};
                    w_units[3] = {24'd0, 2'b10, c[5:0]};
                end
            end
            K_UTF16: begin
                if (c >= LIM_3BYTE) begin
                    w_len      = 3'd2;
                    w_units[0] = {16'd0, w_d[25:10] + HI_SURR_16};
                    w_units[1] = {16'd0, 6'b110111, w_d[9:0]};
                end
            end
            default: begin
                w_len = 3'd1;
            end
        endcase
    end

    assign w_load = !i_empty && (!r_valid || i_out_ready);
    assign w_last = ({1'b0, r_idx} == (w_len - 3'd1));
    assign o_pop  = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_unit <= w_units[r_idx];
            r_len  <= w_len;
            r_last <= w_last;
            r_end  <= w_last && i_head.last_in;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_unit    = r_unit;
    assign o_run_length  = r_len;
    assign o_last_of_run = r_last;
    assign o_end_out     = r_end;

endmodule

[sv/unicode_transcoder.sv]
`timescale 1ns / 1ps
// Unicode transcoder: one source code unit per input word, converted to UTF-8,
// UTF-16 or UTF-32 as set by the source_mode (addr 0) and target_encoding
// (addr 4) registers on the APB port. Any register write drops a held surrogate.
// Input channel: i_code_unit/i_string_end with i_in_valid/o_in_ready.
// Output channel: o_out_unit and run flags with o_out_valid/i_out_ready,
// one output word per cycle while i_out_ready is high and items are queued.
// A front stage classifies each word and joins surrogate pairs, a two-entry
// queue decouples it from the back stage that expands a code point into
// 1 to 4 output words from a registered output.
// Each item is written into a queue entry and then expands into the output
// register. The back stage keeps an item at the queue head until its last
// output word (1 to 4) is loaded into the single-word output register, while
// the front keeps accepting items into free queue entries; a held high
// surrogate or an item under target encoding three produces nothing.
// Reset: source_mode returns to UTF-32, target_encoding to UTF-8, queue and
// output are emptied and no surrogate is held.
// When the receiver stalls, the output word holds, the queue fills, and
// o_in_ready drops once both queue entries are occupied.
module unicode_transcoder
    import ut_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_code_unit,
    input  logic               i_string_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_out_unit,
    output logic [2:0]         o_run_length,
    output logic               o_last_of_run,
    output logic               o_end_out
);

    t_cfg   r_cfg;
    logic   w_cfg_wr;
    logic   w_push;
    logic   w_pop;
    logic   w_empty;
    logic   w_full;
    logic   w_pending;
    t_entry w_entry;
    t_entry w_head;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_mode     <= SRC_MODE_RESET;
            r_cfg.target_encoding <= TGT_ENC_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_SOURCE_MODE) begin
                r_cfg.source_mode <= pwdata[1:0];
            end else begin
                r_cfg.target_encoding <= pwdata[1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_TARGET_ENC) ? {30'd0, r_cfg.target_encoding}
                                                 : {30'd0, r_cfg.source_mode};

    ut_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cfg_wr    (w_cfg_wr),
        .i_valid     (i_in_valid),
        .i_code_unit (i_code_unit),
        .i_string_end(i_string_end),
        .i_full      (w_full),
        .o_ready     (o_in_ready),
        .o_push      (w_push),
        .o_entry     (w_entry),
        .o_pending   (w_pending)
    );

    ut_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_entry(w_entry),
        .i_pop  (w_pop),
        .o_head (w_head),
        .o_empty(w_empty),
        .o_full (w_full)
    );

    ut_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_unit   (o_out_unit),
        .o_run_length (o_run_length),
        .o_last_of_run(o_last_of_run),
        .o_end_out    (o_end_out)
    );

    a_run_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_run_length != 3'd0 && o_run_length <= 3'd4))
        else $error("run length out of range");

    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_out) |-> o_last_of_run)
        else $error("end flag on a word that does not close its run");

    a_single_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_length == 3'd1) |-> o_last_of_run)
        else $error("one-word run without last flag");

    a_cfg_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> !w_pending)
        else $error("surrogate still held after register write");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("queue written while full");

endmodule
